>>> src/mrrt_pkg.sv
// Shared types, constants and codes for the memory region refcount table.
package mrrt_pkg;

    localparam int ENTRIES  = 64;
    localparam int REF_BITS = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = IDX_W + 1;

    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    typedef enum logic [1:0] {
        CMD_REG   = 2'd0,
        CMD_DEREG = 2'd1,
        CMD_GET   = 2'd2,
        CMD_FIND  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BUSY      = 3'd2,
        ST_FULL      = 3'd3,
        ST_SAT       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] addr;
        logic [63:0] length;
        logic [31:0] region_id;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_id;
        logic [63:0] out_base;
        logic [63:0] out_length;
        logic        replaced;
        logic [31:0] replaced_id;
        logic        released;
    } rsp_t;

    // One table entry as stored in the entry memory
    typedef struct packed {
        logic [31:0]         id;
        logic [63:0]         base;
        logic [63:0]         len;
        logic [REF_BITS-1:0] refs;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    // Running result of one scan over the table
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        ent_t             hit_ent;
        logic             cont;
        ent_t             cont_ent;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } scan_res_t;

endpackage

>>> src/mrrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mrrt_scan.sv
// Compare unit that folds one table entry per cycle, while eval is high, into the scan result.
module mrrt_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     eval,
    input  logic [mrrt_pkg::IDX_W-1:0] idx,
    input  logic                     ent_valid,
    input  mrrt_pkg::ent_t           ent,
    input  mrrt_pkg::req_t           key,
    output mrrt_pkg::scan_res_t      res
);
    import mrrt_pkg::*;

    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    ent_t             hit_ent_reg, hit_ent_next;
    logic             cont_reg, cont_next;
    ent_t             cont_ent_reg, cont_ent_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic        key_match;
    logic [64:0] diff;
    logic        contains;
    logic        better;

    // Key compare: id for get, base address otherwise
    assign key_match = ent_valid &&
                       ((key.cmd == CMD_GET) ? (ent.id == key.region_id)
                                             : (ent.base == key.addr));

    // Containment: no borrow means addr >= base, then offset below length
    assign diff     = {1'b0, key.addr} - {1'b0, ent.base};
    assign contains = ent_valid && !diff[64] && (diff[63:0] < ent.len);
    assign better   = contains && (!cont_reg || (ent.id < cont_ent_reg.id));

    // Fold the entry into the running result, keeping the first hit and free slot and the lowest-id container
    always_comb
    begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ent_next  = hit_ent_reg;
        cont_next     = cont_reg;
        cont_ent_next = cont_ent_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        if (start)
        begin
            hit_next  = 1'b0;
            cont_next = 1'b0;
            free_next = 1'b0;
        end
        else if (eval)
        begin
            if (key_match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx;
                hit_ent_next = ent;
            end
            if (better)
            begin
                cont_next     = 1'b1;
                cont_ent_next = ent;
            end
            if (!ent_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = idx;
            end
        end
    end

    // Hold the flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            cont_reg <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            cont_reg <= cont_next;
            free_reg <= free_next;
        end
    end

    // Payload of the scan result
    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        cont_ent_reg <= cont_ent_next;
        free_idx_reg <= free_idx_next;
    end

    assign res.hit      = hit_reg;
    assign res.hit_idx  = hit_idx_reg;
    assign res.hit_ent  = hit_ent_reg;
    assign res.cont     = cont_reg;
    assign res.cont_ent = cont_ent_reg;
    assign res.free     = free_reg;
    assign res.free_idx = free_idx_reg;

endmodule

>>> src/memory_region_refcount_table.sv
// Each item is one command (register, deregister, get by id, find by address) and gives exactly
// one result. The block takes one item at a time: the idle state takes the item, the sequencer
// then reads the entry memory one entry a cycle through its single read port, the compare unit
// folds each entry into the running match in the cycle after its read, a further scan step sees
// the scan drained, and the decide step updates the entry and posts the result. The result sits
// in an output register, so the next item is taken while a result still waits; its decide step
// then waits until that result is taken.
// No clearing pass is needed after reset.
module memory_region_refcount_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mrrt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mrrt_pkg::rsp_t rsp
);
    import mrrt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    req_t               item_reg, item_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]        next_id_reg, next_id_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic             scan_start;
    logic             rd_en;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ent_t             ram_wdata;
    logic [ENT_W-1:0] ram_rdata;
    ent_t             rd_ent;
    ent_t             new_ent;
    scan_res_t        res;
    rsp_t             o;

    assign rd_ent  = ent_t'(ram_rdata);
    assign new_ent = '{id: next_id_reg, base: item_reg.addr, len: item_reg.length,
                       refs: REF_ONE};

    mrrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    mrrt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .eval      (pend_reg),
        .idx       (pend_idx_reg),
        .ent_valid (valid_reg[pend_idx_reg]),
        .ent       (rd_ent),
        .key       (item_reg),
        .res       (res)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer: accept, scan, then decide and post the result
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        item_next      = item_reg;
        valid_next     = valid_reg;
        next_id_next   = next_id_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        scan_start     = 1'b0;
        rd_en          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = res.hit_idx;
        ram_wdata      = res.hit_ent;
        o              = '0;
        o.status       = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    cnt_next   = '0;
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg < CNT_W'(ENTRIES))
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    unique case (item_reg.cmd)
                        CMD_REG:
                        begin
                            if (res.hit && (res.hit_ent.len == item_reg.length))
                            begin
                                o.out_id     = res.hit_ent.id;
                                o.out_base   = res.hit_ent.base;
                                o.out_length = res.hit_ent.len;
                                if (res.hit_ent.refs == REF_MAX)
                                begin
                                    o.status = ST_SAT;
                                end
                                else
                                begin
                                    ram_we         = 1'b1;
                                    ram_wdata.refs = res.hit_ent.refs + REF_ONE;
                                end
                            end
                            else if (res.hit && (res.hit_ent.refs > REF_ONE))
                            begin
                                o.status     = ST_BUSY;
                                o.out_id     = res.hit_ent.id;
                                o.out_base   = res.hit_ent.base;
                                o.out_length = res.hit_ent.len;
                            end
                            else if (res.hit)
                            begin
                                // Replace in place with a fresh id
                                o.replaced    = 1'b1;
                                o.replaced_id = res.hit_ent.id;
                                o.out_id      = next_id_reg;
                                o.out_base    = item_reg.addr;
                                o.out_length  = item_reg.length;
                                ram_we        = 1'b1;
                                ram_wdata     = new_ent;
                                next_id_next  = next_id_reg + 32'd1;
                            end
                            else if (res.free)
                            begin
                                o.out_id               = next_id_reg;
                                o.out_base             = item_reg.addr;
                                o.out_length           = item_reg.length;
                                ram_we                 = 1'b1;
                                ram_waddr              = res.free_idx;
                                ram_wdata              = new_ent;
                                valid_next[res.free_idx] = 1'b1;
                                next_id_next           = next_id_reg + 32'd1;
                            end
                            else
                            begin
                                o.status = ST_FULL;
                            end
                        end
                        CMD_DEREG:
                        begin
                            if (!res.hit)
                            begin
                                o.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                o.out_id     = res.hit_ent.id;
                                o.out_base   = res.hit_ent.base;
                                o.out_length = res.hit_ent.len;
                                if (res.hit_ent.refs > REF_ONE)
                                begin
                                    ram_we         = 1'b1;
                                    ram_wdata.refs = res.hit_ent.refs - REF_ONE;
                                end
                                else
                                begin
                                    valid_next[res.hit_idx] = 1'b0;
                                    o.released              = 1'b1;
                                end
                            end
                        end
                        CMD_GET:
                        begin
                            if (!res.hit)
                            begin
                                o.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                o.out_id     = res.hit_ent.id;
                                o.out_base   = res.hit_ent.base;
                                o.out_length = res.hit_ent.len;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (res.hit)
                            begin
                                o.out_id     = res.hit_ent.id;
                                o.out_base   = res.hit_ent.base;
                                o.out_length = res.hit_ent.len;
                            end
                            else if (res.cont)
                            begin
                                o.out_id     = res.cont_ent.id;
                                o.out_base   = res.cont_ent.base;
                                o.out_length = res.cont_ent.len;
                            end
                            else
                            begin
                                o.status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                    rsp_next       = o;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            next_id_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            next_id_reg   <= next_id_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        item_reg     <= item_next;
        rsp_reg      <= rsp_next;
    end

    // A new result is posted only from the decide step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result posted outside decide step");

    // The id counter advances only together with an entry write
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(next_id_reg) |-> $past(ram_we) && $past(state_reg == S_DECIDE))
        else $error("next id moved without an insert");

    // Valid bits change only in the decide step
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(valid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("valid bits changed outside decide step");

    // The scan counter never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("scan counter out of range");

    // Memory reads happen only while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == S_SCAN))
        else $error("entry read outside scan");

endmodule
